@@ src/gda_pkg.sv @@
`timescale 1ns / 1ps
// gda_pkg: shared types, constants and calendar helpers for the date unit
// used by gda_step and gregorian_date_arithmetic_unit; no dependencies

package gda_pkg;

  // field widths
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int ACTION_W = 3;

  // number of offset bits taken from the day_offset field
  localparam int OFFSET_WIDTH = 16;

  // held year limits
  localparam int MIN_YEAR = 1900;
  localparam int MAX_YEAR = 9999;

  // month codes and lengths that need naming
  localparam logic [MONTH_W-1:0] JAN = 4'd1;
  localparam logic [MONTH_W-1:0] FEB = 4'd2;
  localparam logic [MONTH_W-1:0] DEC = 4'd12;
  localparam logic [DAY_W-1:0]   LEAP_FEB_LEN = 5'd29;
  localparam logic [DAY_W-1:0]   DEC_LEN      = 5'd31;

  // floor(y / 100) as (y * RECIP_100) >> RECIP_SHIFT, exact for any 14-bit year
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = 13;
  localparam int PROD_W      = YEAR_W + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

  // action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_SET  = 3'd0,
    ACT_NEXT = 3'd1,
    ACT_PREV = 3'd2,
    ACT_ADD  = 3'd3,
    ACT_CMP  = 3'd4
  } action_t;

  // month lengths in a common year, zero for codes that are no month
  localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  // request to the month step unit
  typedef struct packed {
    logic [YEAR_W-1:0]       year;
    logic [MONTH_W-1:0]      month;
    logic [DAY_W-1:0]        day;
    logic [OFFSET_WIDTH-1:0] rem;
    logic                    back;
    logic                    leap;
  } step_req_t;

  // outcome of one month step
  typedef struct packed {
    logic [YEAR_W-1:0]       year;
    logic [MONTH_W-1:0]      month;
    logic [DAY_W-1:0]        day;
    logic [OFFSET_WIDTH-1:0] rem;
    logic                    done;
    logic                    sat;
    logic                    year_chg;
  } step_res_t;

  // length of a month given the leap flag of its year
  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                               input logic leap);
    logic [DAY_W-1:0] len;
    len = MONTH_LEN[month];
    if (month == FEB && leap) len = LEAP_FEB_LEN;
    return len;
  endfunction

endpackage

@@ src/gda_step.sv @@
`timescale 1ns / 1ps
// gda_step: shared month step unit, moves a date by up to one month per use
// depends on gda_pkg

module gda_step (
  input  gda_pkg::step_req_t req,
  output gda_pkg::step_res_t res
);

  logic [gda_pkg::DAY_W-1:0]        mlen;
  logic [gda_pkg::DAY_W-1:0]        left;
  logic [gda_pkg::DAY_W-1:0]        prev_len;
  logic [gda_pkg::MONTH_W-1:0]      prev_month;
  logic                             at_top;
  logic                             at_bottom;

  assign mlen       = gda_pkg::days_in(req.month, req.leap);
  assign left       = mlen - req.day;
  assign prev_month = req.month - 4'd1;
  assign prev_len   = gda_pkg::days_in(prev_month, req.leap);
  assign at_top     = (req.year == gda_pkg::YEAR_W'(gda_pkg::MAX_YEAR)) &&
                      (req.month == gda_pkg::DEC);
  assign at_bottom  = (req.year == gda_pkg::YEAR_W'(gda_pkg::MIN_YEAR)) &&
                      (req.month == gda_pkg::JAN);

  // one step: finish inside this month, saturate, or cross into the neighbour
  always_comb begin
    res          = '0;
    res.year     = req.year;
    res.month    = req.month;
    res.day      = req.day;
    res.rem      = req.rem;
    if (!req.back) begin
      if (req.rem <= gda_pkg::OFFSET_WIDTH'(left)) begin
        res.day  = req.day + req.rem[gda_pkg::DAY_W-1:0];
        res.rem  = '0;
        res.done = 1'b1;
      end else if (at_top) begin
        res.day  = gda_pkg::DEC_LEN;
        res.rem  = '0;
        res.done = 1'b1;
        res.sat  = 1'b1;
      end else begin
        // land on the first of the next month
        res.rem = req.rem - gda_pkg::OFFSET_WIDTH'(left) - 1'b1;
        res.day = 5'd1;
        if (req.month == gda_pkg::DEC) begin
          res.month    = gda_pkg::JAN;
          res.year     = req.year + 1'b1;
          res.year_chg = 1'b1;
        end else begin
          res.month = req.month + 1'b1;
        end
      end
    end else begin
      if (req.rem < gda_pkg::OFFSET_WIDTH'(req.day)) begin
        res.day  = req.day - req.rem[gda_pkg::DAY_W-1:0];
        res.rem  = '0;
        res.done = 1'b1;
      end else if (at_bottom) begin
        res.day  = 5'd1;
        res.rem  = '0;
        res.done = 1'b1;
        res.sat  = 1'b1;
      end else begin
        // land on the last day of the previous month
        res.rem = req.rem - gda_pkg::OFFSET_WIDTH'(req.day);
        if (req.month == gda_pkg::JAN) begin
          res.month    = gda_pkg::DEC;
          res.day      = gda_pkg::DEC_LEN;
          res.year     = req.year - 1'b1;
          res.year_chg = 1'b1;
        end else begin
          res.month = prev_month;
          res.day   = prev_len;
        end
      end
    end
  end

endmodule

@@ src/gregorian_date_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// gregorian_date_arithmetic_unit: top level, sequencer, held date and output register
// depends on gda_pkg and gda_step

// Holds one Gregorian date and runs one action per input word: set, next day,
// previous day, add a signed day offset, or compare. One word is worked on at a
// time; s_tready is high only while the sequencer is idle, and a finished result
// sits in the output register so the next word can be taken while it waits.
// Compare and unused action codes go from S_EXEC straight to S_DONE; set passes
// S_LEAP_Q, S_LEAP_F and S_SET; day steps and offset adds pass the leap states, then
// S_WALK, where the shared month step unit crosses one month per step and each
// year boundary crossed returns to the leap states (the leap flag of the new year
// is worked out in two steps, S_LEAP_Q and S_LEAP_F, by a reciprocal multiply).

module gregorian_date_arithmetic_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // in_year[13:0], in_month[17:14], in_day[22:18],
                                // day_offset[38:23], zero fill[39]
  input  logic [2:0]  s_tuser,  // action[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // out_year[13:0], out_month[17:14], out_day[22:18],
                                // zero fill[23]
  output logic [4:0]  m_tuser   // is_greater[0], is_equal[1], is_less[2],
                                // rejected[3], range_flag[4]
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_LEAP_Q = 7'b0000100,
    S_LEAP_F = 7'b0001000,
    S_SET    = 7'b0010000,
    S_WALK   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;

  // held date
  logic [gda_pkg::YEAR_W-1:0]  year_reg;
  logic [gda_pkg::MONTH_W-1:0] month_reg;
  logic [gda_pkg::DAY_W-1:0]   day_reg;

  // latched input word
  logic [gda_pkg::ACTION_W-1:0]     act_r;
  logic [gda_pkg::YEAR_W-1:0]       in_year_r;
  logic [gda_pkg::MONTH_W-1:0]      in_month_r;
  logic [gda_pkg::DAY_W-1:0]        in_day_r;
  logic [gda_pkg::OFFSET_WIDTH-1:0] off_r;

  // walk state and flags
  logic [gda_pkg::OFFSET_WIDTH-1:0] rem;
  logic                             back;
  logic [gda_pkg::QUOT_W-1:0]       quot;
  logic                             leap;
  logic                             gt;
  logic                             eq;
  logic                             lt;
  logic                             rej;
  logic                             rf;

  logic [gda_pkg::YEAR_W-1:0]  leap_year;
  logic [gda_pkg::PROD_W-1:0]  prod;
  logic [gda_pkg::YEAR_W-1:0]  hundreds;
  logic                        div100;
  logic                        set_ok;
  logic                        load_out;
  logic [22:0]                 held_cat;
  logic [22:0]                 in_cat;
  gda_pkg::step_req_t          step_req;
  gda_pkg::step_res_t          step_res;

  assign s_tready = (state == S_IDLE);
  assign load_out = (state == S_DONE) && (!m_tvalid || m_tready);

  // leap test: the year a set names, otherwise the held one
  assign leap_year = (act_r == gda_pkg::ACT_SET) ? in_year_r : year_reg;
  assign prod      = gda_pkg::PROD_W'(leap_year) * gda_pkg::PROD_W'(gda_pkg::RECIP_100);
  assign hundreds  = (gda_pkg::YEAR_W'(quot) << 6) + (gda_pkg::YEAR_W'(quot) << 5) +
                     (gda_pkg::YEAR_W'(quot) << 2);
  assign div100    = (hundreds == leap_year);

  // validity of a set
  assign set_ok = (in_year_r >= gda_pkg::YEAR_W'(gda_pkg::MIN_YEAR)) &&
                  (in_year_r <= gda_pkg::YEAR_W'(gda_pkg::MAX_YEAR)) &&
                  (in_month_r >= gda_pkg::JAN) && (in_month_r <= gda_pkg::DEC) &&
                  (in_day_r != '0) &&
                  (in_day_r <= gda_pkg::days_in(in_month_r, leap));

  // compare orders by year, then month, then day
  assign held_cat = {year_reg, month_reg, day_reg};
  assign in_cat   = {in_year_r, in_month_r, in_day_r};

  // shared month step unit
  assign step_req.year  = year_reg;
  assign step_req.month = month_reg;
  assign step_req.day   = day_reg;
  assign step_req.rem   = rem;
  assign step_req.back  = back;
  assign step_req.leap  = leap;

  gda_step u_step (
    .req (step_req),
    .res (step_res)
  );

  // sequencer, held date and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      year_reg  <= gda_pkg::YEAR_W'(gda_pkg::MIN_YEAR);
      month_reg <= gda_pkg::JAN;
      day_reg   <= 5'd1;
      m_tvalid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_EXEC;
        end
        S_EXEC: begin
          case (act_r)
            gda_pkg::ACT_SET, gda_pkg::ACT_NEXT, gda_pkg::ACT_PREV,
            gda_pkg::ACT_ADD: state <= S_LEAP_Q;
            default:          state <= S_DONE;
          endcase
        end
        S_LEAP_Q: state <= S_LEAP_F;
        S_LEAP_F: begin
          if (act_r == gda_pkg::ACT_SET) state <= S_SET;
          else                           state <= S_WALK;
        end
        S_SET: begin
          if (set_ok) begin
            year_reg  <= in_year_r;
            month_reg <= in_month_r;
            day_reg   <= in_day_r;
          end
          state <= S_DONE;
        end
        S_WALK: begin
          year_reg  <= step_res.year;
          month_reg <= step_res.month;
          day_reg   <= step_res.day;
          if (step_res.done)          state <= S_DONE;
          else if (step_res.year_chg) state <= S_LEAP_Q;
        end
        S_DONE: begin
          if (load_out) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (load_out)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // payload: latched word, walk counter, leap flag, result flags, output word
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          act_r      <= s_tuser;
          in_year_r  <= s_tdata[13:0];
          in_month_r <= s_tdata[17:14];
          in_day_r   <= s_tdata[22:18];
          off_r      <= s_tdata[38:23];
        end
      end
      S_EXEC: begin
        gt  <= 1'b0;
        eq  <= 1'b0;
        lt  <= 1'b0;
        rej <= 1'b0;
        rf  <= 1'b0;
        case (act_r)
          gda_pkg::ACT_NEXT: begin
            rem  <= gda_pkg::OFFSET_WIDTH'(1);
            back <= 1'b0;
          end
          gda_pkg::ACT_PREV: begin
            rem  <= gda_pkg::OFFSET_WIDTH'(1);
            back <= 1'b1;
          end
          gda_pkg::ACT_ADD: begin
            back <= off_r[gda_pkg::OFFSET_WIDTH-1];
            rem  <= off_r[gda_pkg::OFFSET_WIDTH-1] ? (~off_r + 1'b1) : off_r;
          end
          gda_pkg::ACT_CMP: begin
            gt <= (held_cat > in_cat);
            eq <= (held_cat == in_cat);
            lt <= (held_cat < in_cat);
          end
          default: ;
        endcase
      end
      S_LEAP_Q: quot <= prod[gda_pkg::PROD_W-1:gda_pkg::RECIP_SHIFT];
      S_LEAP_F: leap <= (leap_year[1:0] == 2'b00 && !div100) ||
                        (div100 && leap_year[3:0] == 4'b0000);
      S_SET:    rej  <= !set_ok;
      S_WALK: begin
        rem <= step_res.rem;
        if (step_res.done) rf <= step_res.sat;
      end
      S_DONE: begin
        if (load_out) begin
          m_tdata <= {1'b0, day_reg, month_reg, year_reg};
          m_tuser <= {rf, rej, lt, eq, gt};
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_held_valid: assert property (@(posedge clk) disable iff (rst)
    (month_reg >= gda_pkg::JAN) && (month_reg <= gda_pkg::DEC) && (day_reg != '0))
    else $error("held date has an impossible month or day");

  a_out_year: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[13:0] >= gda_pkg::YEAR_W'(gda_pkg::MIN_YEAR)) &&
                 (m_tdata[13:0] <= gda_pkg::YEAR_W'(gda_pkg::MAX_YEAR)))
    else $error("result year outside the held range");

  a_cmp_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tuser[2:0]))
    else $error("more than one compare flag set");

  a_flag_mix: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[3] && m_tuser[4]) &&
                 !((m_tuser[3] || m_tuser[4]) && (m_tuser[2:0] != 3'b000)))
    else $error("flags of different actions set together");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_EXEC))
    else $error("accepted word did not start the sequencer");
`endif

endmodule
